>>> sv/assert_macros.svh
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check that an implication holds at every clock edge outside reset.
`define ASSERT_HOLDS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that a condition never comes true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_HOLDS(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

>>> sv/dqa_pkg.sv
// Types and constants of the dotted-quad address parser.
`timescale 1ns / 1ps
package dqa_pkg;

    // Character codes
    localparam logic [7:0] CH_NUL  = 8'h00;
    localparam logic [7:0] CH_DOT  = 8'h2E;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;

    // Result status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_BADCHAR = 3'd1;
    localparam logic [2:0] ST_EMPTY   = 3'd2;
    localparam logic [2:0] ST_OVER    = 3'd3;
    localparam logic [2:0] ST_FEW     = 3'd4;

    // Part limits
    localparam logic [8:0] PART_MAX   = 9'd255;
    localparam logic [8:0] PART_SAT   = 9'd256;
    localparam logic [2:0] PART_COUNT = 3'd4;

    typedef enum logic [1:0] {
        KIND_DIGIT,
        KIND_DOT,
        KIND_END,
        KIND_OTHER
    } kind_t;

    // One classified character
    typedef struct packed {
        kind_t      kind;
        logic [3:0] digit;
    } token_t;

    // Token queue read side, as seen by the back end
    typedef struct packed {
        logic   valid;
        token_t token;
    } tok_slot_t;

endpackage

>>> sv/dqa_front.sv
// Front end: classifies each incoming character into a token.
`timescale 1ns / 1ps
module dqa_front
    import dqa_pkg::*;
(
    input  logic [7:0] ch,
    input  logic       push,
    input  logic       q_full,
    output logic       wr_en,
    output token_t     token
);

    // Accept a character whenever the token queue has room
    assign wr_en = push && !q_full;

    // Classify the character and extract its digit value
    always_comb
    begin
        token.digit = 4'd0;
        if (ch == CH_NUL)
        begin
            token.kind = KIND_END;
        end
        else if (ch == CH_DOT)
        begin
            token.kind = KIND_DOT;
        end
        else if (ch inside {[CH_ZERO:CH_NINE]})
        begin
            token.kind  = KIND_DIGIT;
            token.digit = 4'(ch - CH_ZERO);
        end
        else
        begin
            token.kind = KIND_OTHER;
        end
    end

endmodule

>>> sv/dqa_queue.sv
// Two-entry token queue between the front and back ends.
`timescale 1ns / 1ps
module dqa_queue
    import dqa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      wr_en,
    input  token_t    wr_token,
    input  logic      rd_en,
    output logic      full,
    output tok_slot_t head
);

    token_t     entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full        = (count_reg == 2'd2);
    assign head.valid  = (count_reg != 2'd0);
    assign head.token  = entry_reg[rd_ptr_reg];

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ wr_en;
        rd_ptr_next = rd_ptr_reg ^ rd_en;
        count_next  = count_reg + {1'b0, wr_en} - {1'b0, rd_en};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the written token
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_reg[wr_ptr_reg] <= wr_token;
        end
    end

endmodule

>>> sv/dqa_back.sv
// Back end: runs the part accumulator and holds the result register.
`timescale 1ns / 1ps
module dqa_back
    import dqa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  tok_slot_t   head,
    output logic        rd_en,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  status,
    output logic [31:0] address
);

    logic [8:0]  part_value_reg;
    logic [8:0]  part_value_next;
    logic        digit_seen_reg;
    logic        digit_seen_next;
    logic [2:0]  part_index_reg;
    logic [2:0]  part_index_next;
    logic [31:0] address_acc_reg;
    logic [31:0] address_acc_next;
    logic [2:0]  error_code_reg;
    logic [2:0]  error_code_next;
    logic        res_valid_reg;
    logic        res_valid_next;
    logic [2:0]  status_reg;
    logic [2:0]  status_next;
    logic [31:0] address_reg;
    logic [31:0] address_next;

    logic        res_pop;
    logic        busy;
    logic [11:0] scaled;
    logic [2:0]  index_inc;
    logic [31:0] acc_shifted;

    assign empty   = !res_valid_reg;
    assign status  = status_reg;
    assign address = address_reg;
    assign res_pop = pop && res_valid_reg;

    // Take a token unless it ends the string and the result slot stays occupied
    assign rd_en = head.valid
        && ((head.token.kind != KIND_END) || !res_valid_reg || res_pop);

    assign busy        = (error_code_reg == ST_OK) && (part_index_reg < PART_COUNT);
    assign scaled      = {part_value_reg, 3'b000} + {2'b00, part_value_reg, 1'b0}
                         + {8'd0, head.token.digit};
    assign index_inc   = part_index_reg + 3'd1;
    assign acc_shifted = {address_acc_reg[23:0], part_value_reg[7:0]};

    // Update parser state and result slot
    always_comb
    begin
        part_value_next  = part_value_reg;
        digit_seen_next  = digit_seen_reg;
        part_index_next  = part_index_reg;
        address_acc_next = address_acc_reg;
        error_code_next  = error_code_reg;
        res_valid_next   = res_valid_reg && !res_pop;
        status_next      = status_reg;
        address_next     = address_reg;

        if (rd_en)
        begin
            case (head.token.kind)
                KIND_END:
                begin
                    res_valid_next = 1'b1;
                    address_next   = 32'd0;
                    if (error_code_reg != ST_OK)
                    begin
                        status_next = error_code_reg;
                    end
                    else if (!busy)
                    begin
                        status_next  = ST_OK;
                        address_next = address_acc_reg;
                    end
                    else if (!digit_seen_reg)
                    begin
                        status_next = ST_FEW;
                    end
                    else if (part_value_reg > PART_MAX)
                    begin
                        status_next = ST_OVER;
                    end
                    else if (index_inc < PART_COUNT)
                    begin
                        status_next = ST_FEW;
                    end
                    else
                    begin
                        status_next  = ST_OK;
                        address_next = acc_shifted;
                    end
                    // Return to the reset state for the next string
                    part_value_next  = 9'd0;
                    digit_seen_next  = 1'b0;
                    part_index_next  = 3'd0;
                    address_acc_next = 32'd0;
                    error_code_next  = ST_OK;
                end
                KIND_DOT:
                begin
                    if (busy)
                    begin
                        if (!digit_seen_reg)
                        begin
                            error_code_next = ST_EMPTY;
                        end
                        else if (part_value_reg > PART_MAX)
                        begin
                            error_code_next = ST_OVER;
                        end
                        else
                        begin
                            address_acc_next = acc_shifted;
                            part_index_next  = index_inc;
                        end
                        part_value_next = 9'd0;
                        digit_seen_next = 1'b0;
                    end
                end
                KIND_DIGIT:
                begin
                    if (busy)
                    begin
                        part_value_next = (scaled > {3'b000, PART_SAT})
                            ? PART_SAT : scaled[8:0];
                        digit_seen_next = 1'b1;
                    end
                end
                default:
                begin
                    if (busy)
                    begin
                        error_code_next = ST_BADCHAR;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            part_value_reg  <= 9'd0;
            digit_seen_reg  <= 1'b0;
            part_index_reg  <= 3'd0;
            address_acc_reg <= 32'd0;
            error_code_reg  <= ST_OK;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            part_value_reg  <= part_value_next;
            digit_seen_reg  <= digit_seen_next;
            part_index_reg  <= part_index_next;
            address_acc_reg <= address_acc_next;
            error_code_reg  <= error_code_next;
            res_valid_reg   <= res_valid_next;
        end
    end

    // Hold the result payload
    always_ff @(posedge clk)
    begin
        status_reg  <= status_next;
        address_reg <= address_next;
    end

endmodule

>>> sv/dotted_quad_address_parser.sv
// Dotted-quad address parser: one character per cycle in, one result per string.
// Throughput: one character per cycle while the result is taken in time.
// A terminating NUL is written into the token queue, then read from it into the result register.
// The front classifies characters into a two-entry queue; the back end accumulates
// parts and fills a one-entry result register. Async active-low reset empties
// the token queue and the result register and clears all parser state.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module dotted_quad_address_parser
    import dqa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  ch,
    input  logic        push,
    output logic        full,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  status,
    output logic [31:0] address
);

    logic      wr_en;
    logic      rd_en;
    token_t    wr_token;
    tok_slot_t head;

    dqa_front u_front (
        .ch     (ch),
        .push   (push),
        .q_full (full),
        .wr_en  (wr_en),
        .token  (wr_token)
    );

    dqa_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_token (wr_token),
        .rd_en    (rd_en),
        .full     (full),
        .head     (head)
    );

    dqa_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (head),
        .rd_en   (rd_en),
        .empty   (empty),
        .pop     (pop),
        .status  (status),
        .address (address)
    );

    `ASSERT_HOLDS(a_status_range, clk, rst_n, !empty |-> (status <= ST_FEW), "status code out of range")
    `ASSERT_HOLDS(a_err_addr_zero, clk, rst_n, (!empty && status != ST_OK) |-> (address == 32'd0), "address nonzero on error")
    `ASSERT_HOLDS(a_full_has_head, clk, rst_n, full |-> head.valid, "queue full but head empty")
    `ASSERT_NEVER(a_read_empty, clk, rst_n, rd_en && !head.valid, "token read from empty queue")

endmodule
